// ===== rtl/dual_move_to_end_symbol_table_macros.svh =====
// Assertion macros used by the symbol table top level.
// Each macro expects signals named clk and rst in the including scope.
`ifndef DUAL_MOVE_TO_END_SYMBOL_TABLE_MACROS_SVH
`define DUAL_MOVE_TO_END_SYMBOL_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define DMTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define DMTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DMTE_ASSERT_NOW(label, ante, cons)
`define DMTE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/dmte_pkg.sv =====
// Package for the dual move-to-end symbol table: types, field widths, codes.
// No dependencies.
`timescale 1ns / 1ps
package dmte_pkg;

  localparam int DEF_ENTRIES_PER_TABLE = 32;
  localparam int DEF_TABLE_COUNT       = 2;

  // field widths of the words on both streams
  localparam int INDEX_W    = 6;
  localparam int SYMBOL_W   = 8;
  localparam int READ_W     = 5;
  localparam int S_TDATA_W  = 16;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 8;
  localparam int M_TUSER_W  = 1;

  localparam logic MODE_READ = 1'b0;
  localparam logic MODE_MOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    logic busy;
    logic match_en;
    logic shift_en;
  } ctl_t;

endpackage

// ===== rtl/dmte_cell.sv =====
// One entry of a recency table: holds its symbol, compares, shifts from neighbor.
// Depends on dmte_pkg.
`timescale 1ns / 1ps
module dmte_cell #(
  parameter int ENTRY_W   = 5,
  parameter int POS       = 0,
  parameter int RESET_VAL = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  dmte_pkg::ctl_t     ctl,
  input  logic               sel,
  input  logic [ENTRY_W-1:0] sym,
  input  logic [ENTRY_W-1:0] nbr,
  input  logic               found,
  input  logic [ENTRY_W-1:0] pos,
  output logic [ENTRY_W-1:0] val,
  output logic               hit,
  output logic [ENTRY_W-1:0] hit_pos
);
  import dmte_pkg::*;

  assign hit     = sel && (val == sym);
  assign hit_pos = hit ? ENTRY_W'(POS) : '0;

  // cells at or after the found slot take the neighbor's entry
  always_ff @(posedge clk) begin
    if (rst) begin
      val <= ENTRY_W'(RESET_VAL);
    end else if (ctl.shift_en && sel && found && (ENTRY_W'(POS) >= pos)) begin
      val <= nbr;
    end
  end

endmodule

// ===== rtl/dmte_ctrl.sv =====
// Sequencer for a move: match cycle, then shift cycle.
// Depends on dmte_pkg.
`timescale 1ns / 1ps
module dmte_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output dmte_pkg::ctl_t ctl
);
  import dmte_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_MATCH;
      ST_MATCH: state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE: begin
        ctl = '0;
      end
      ST_MATCH: begin
        ctl.busy     = 1'b1;
        ctl.match_en = 1'b1;
      end
      ST_SHIFT: begin
        ctl.busy     = 1'b1;
        ctl.shift_en = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

// ===== rtl/dual_move_to_end_symbol_table.sv =====
// Top level of the dual move-to-end symbol table: cell rows, sequencer, output register.
// Depends on dmte_pkg, dmte_cell, dmte_ctrl and the assertion macro header.
//
//  channel   dir  fields (low bit first)                          handshake
//  s_*       in   tdata: entry_index[5:0] symbol[13:6]            tvalid/tready
//                 tuser: mode[0] table_select[1]
//  m_*       out  tdata: read_value[4:0]; tuser: rejected[0]     tvalid/tready
//
// A read word is picked from its entry at accept and lands in the output
// register. A move word also posts its result at accept, then holds the input
// off while the serial sequencer over the cell row runs its match state, then
// its shift state. A rejected move, or one with a table select beyond the
// table count, posts its result without starting the sequencer.
// Synchronous reset loads every table with ENTRIES_PER_TABLE-1 down to 0.
// The output register frees the input side; s_tready drops only while the
// sequencer is busy or a result waits that is not taken this cycle.
`timescale 1ns / 1ps
`include "dual_move_to_end_symbol_table_macros.svh"
module dual_move_to_end_symbol_table #(
  parameter int ENTRIES_PER_TABLE = dmte_pkg::DEF_ENTRIES_PER_TABLE,
  parameter int TABLE_COUNT       = dmte_pkg::DEF_TABLE_COUNT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dmte_pkg::S_TDATA_W-1:0] s_tdata,   // entry_index, symbol
  input  logic [dmte_pkg::S_TUSER_W-1:0] s_tuser,   // mode, table_select
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dmte_pkg::M_TDATA_W-1:0] m_tdata,   // read_value
  output logic [dmte_pkg::M_TUSER_W-1:0] m_tuser    // rejected
);
  import dmte_pkg::*;

  localparam int TOTAL   = ENTRIES_PER_TABLE * TABLE_COUNT;
  localparam int ENTRY_W = $clog2(ENTRIES_PER_TABLE);
  localparam int ADDR_W  = $clog2(TOTAL);
  // compare width that holds both the index field and the store size
  localparam int CMP_W   = (ADDR_W + 1 > INDEX_W + 1) ? ADDR_W + 1 : INDEX_W + 1;
  localparam int TSEL_W  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;

  // unpack input word
  logic                in_mode;
  logic                in_tsel;
  logic [INDEX_W-1:0]  in_index;
  logic [SYMBOL_W-1:0] in_symbol;

  assign in_mode   = s_tuser[0];
  assign in_tsel   = s_tuser[1];
  assign in_index  = s_tdata[INDEX_W-1:0];
  assign in_symbol = s_tdata[INDEX_W +: SYMBOL_W];

  ctl_t ctl;
  logic accept;
  logic sym_ok;
  logic tsel_ok;
  logic start;

  assign s_tready = !ctl.busy && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign sym_ok   = {1'b0, in_symbol} <= (SYMBOL_W + 1)'(ENTRIES_PER_TABLE - 1);
  assign tsel_ok  = 32'(in_tsel) < 32'(TABLE_COUNT);
  assign start    = accept && (in_mode == MODE_MOVE) && sym_ok && tsel_ok;

  dmte_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ctl   (ctl)
  );

  // move operands, latched when a valid move is accepted
  logic [ENTRY_W-1:0] sym_r;
  logic [TSEL_W-1:0]  tsel_r;

  always_ff @(posedge clk) begin
    if (start) begin
      sym_r  <= ENTRY_W'(in_symbol);
      tsel_r <= TSEL_W'(in_tsel);
    end
  end

  // cell row
  logic [ENTRY_W-1:0] vals    [TOTAL];
  logic [ENTRY_W-1:0] hit_pos [TOTAL];
  logic [TOTAL-1:0]   hits;
  logic               found;
  logic [ENTRY_W-1:0] pos;

  for (genvar t = 0; t < TABLE_COUNT; t++) begin : g_table
    logic sel;
    assign sel = (tsel_r == TSEL_W'(t));
    for (genvar j = 0; j < ENTRIES_PER_TABLE; j++) begin : g_cell
      logic [ENTRY_W-1:0] nbr;
      if (j == ENTRIES_PER_TABLE - 1) begin : g_last
        assign nbr = sym_r;        // last slot takes the moved symbol
      end else begin : g_mid
        assign nbr = vals[t * ENTRIES_PER_TABLE + j + 1];
      end
      dmte_cell #(
        .ENTRY_W   (ENTRY_W),
        .POS       (j),
        .RESET_VAL (ENTRIES_PER_TABLE - 1 - j)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .sel     (sel),
        .sym     (sym_r),
        .nbr     (nbr),
        .found   (found),
        .pos     (pos),
        .val     (vals[t * ENTRIES_PER_TABLE + j]),
        .hit     (hits[t * ENTRIES_PER_TABLE + j]),
        .hit_pos (hit_pos[t * ENTRIES_PER_TABLE + j])
      );
    end
  end

  // match position: at most one cell hits, so an OR picks its slot
  logic [ENTRY_W-1:0] pos_any;

  always_comb begin
    pos_any = '0;
    for (int i = 0; i < TOTAL; i++) begin
      pos_any = pos_any | hit_pos[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.match_en) begin
      found <= |hits;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.match_en) begin
      pos <= pos_any;
    end
  end

  // read path: out-of-range index reads entry 0
  logic [CMP_W-1:0]  idx_ext;
  logic [ADDR_W-1:0] rd_addr;
  logic [READ_W-1:0] rd_val;

  assign idx_ext = CMP_W'(in_index);
  assign rd_addr = (idx_ext < CMP_W'(TOTAL)) ? ADDR_W'(idx_ext) : '0;
  assign rd_val  = READ_W'(vals[rd_addr]);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= (in_mode == MODE_READ) ? M_TDATA_W'(rd_val) : '0;
      m_tuser <= M_TUSER_W'((in_mode == MODE_MOVE) && !sym_ok);
    end
  end

  // a valid move keeps the input closed while the cells work
  `DMTE_ASSERT_NEXT(a_move_blocks, start, !s_tready && ctl.match_en)
  // tables stay permutations, so a move always finds its symbol
  `DMTE_ASSERT_NOW(a_move_found, ctl.shift_en, found)
  // no symbol sits twice in one table
  `DMTE_ASSERT_NOW(a_single_hit, ctl.match_en, $onehot0(hits))
  // a rejected move carries a zero read value
  `DMTE_ASSERT_NOW(a_reject_zero, m_tvalid && m_tuser[0], m_tdata == '0)

endmodule
